// File: hw/rtl/mexp_pkg.sv
// shared constants and state types for the prime-modulus exponentiation block
// no dependencies; imported by mexp_modmul and modular_exponentiation_prime
`timescale 1ns / 1ps

package mexp_pkg;

    // prime modulus and derived constants
    localparam logic [29:0] MOD        = 30'd1000000009;
    localparam logic [29:0] INV_EXP    = 30'd1000000007;   // modulus minus two
    localparam logic [31:0] MOD_X2     = 32'd2000000018;   // twice the modulus
    // barrett factor floor(2^60 / modulus)
    localparam logic [30:0] BARRETT_MU = 31'd1152921494;

    // modular multiplier steps
    typedef enum logic [1:0] {
        MM_IDLE,
        MM_QEST,
        MM_QP,
        MM_RED
    } t_mm_state;

    // top level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/mexp_modmul.sv
// modular multiplier: one shared 31x31 multiplier reused for product and barrett steps
// depends on mexp_pkg
`timescale 1ns / 1ps

module mexp_modmul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [29:0] i_a,
    input  logic [29:0] i_b,
    output logic        o_done,
    output logic [29:0] o_product
);
    import mexp_pkg::*;

    t_mm_state   r_state, n_state;
    logic [61:0] r_prod, n_prod;
    logic [31:0] r_xlo, n_xlo;
    logic [30:0] op_a, op_b;
    logic [61:0] mul_out;
    logic        mul_en;
    logic [31:0] diff;
    logic [32:0] diff1, diff2;

    // shared multiplier
    assign mul_out = op_a * op_b;

    // step sequencing and operand selection
    always_comb begin
        n_state = r_state;
        n_xlo   = r_xlo;
        op_a    = {1'b0, i_a};
        op_b    = {1'b0, i_b};
        mul_en  = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            MM_IDLE: begin
                if (i_start) begin
                    mul_en  = 1'b1;
                    n_state = MM_QEST;
                end
            end
            MM_QEST: begin
                // quotient estimate from the top bits of the product
                op_a    = r_prod[59:29];
                op_b    = BARRETT_MU;
                mul_en  = 1'b1;
                n_xlo   = r_prod[31:0];
                n_state = MM_QP;
            end
            MM_QP: begin
                op_a    = r_prod[61:31];
                op_b    = {1'b0, MOD};
                mul_en  = 1'b1;
                n_state = MM_RED;
            end
            MM_RED: begin
                o_done  = 1'b1;
                n_state = MM_IDLE;
            end
            default: begin
                n_state = MM_IDLE;
            end
        endcase
        n_prod = mul_en ? mul_out : r_prod;
    end

    // final reduction: remainder is below three times the modulus
    always_comb begin
        diff  = r_xlo - r_prod[31:0];
        diff1 = {1'b0, diff} - {3'b000, MOD};
        diff2 = {1'b0, diff} - {1'b0, MOD_X2};
        if (!diff2[32]) begin
            o_product = diff2[29:0];
        end else if (!diff1[32]) begin
            o_product = diff1[29:0];
        end else begin
            o_product = diff[29:0];
        end
    end

    // step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_xlo  <= n_xlo;
    end

endmodule

// File: hw/rtl/modular_exponentiation_prime.sv
// top level: square-and-multiply exponentiation modulo 1000000009
// depends on mexp_pkg and mexp_modmul
`timescale 1ns / 1ps

// Usage
//   Input channel: i_in_valid with i_operation, i_base_value, i_exponent; the
//   block raises o_in_stall while an item is in progress. Operation 0 gives
//   base to the exponent (low EXP_BITS bits), operation 1 gives the inverse.
//   Output channel: o_out_valid with o_residue; the receiver drives i_out_stall.
//   Each modular multiply runs in the shared multiplier in steps (product,
//   quotient estimate, quotient times modulus, reduce). Every exponent bit
//   costs one square and, for a set bit, one multiply. A zero base skips the
//   squares and multiplies and goes straight to the result.
//   One item is in work at a time; the next is accepted once the result has
//   moved to the output register, even while that result is still stalled.
//   A stalled result holds in the output register; a finished item waits
//   in its last state until the output register is free.
//   Reset (synchronous, active low) returns to idle and drops o_out_valid.

module modular_exponentiation_prime #(
    parameter int EXP_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [29:0] i_base_value,
    input  logic [31:0] i_exponent,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [29:0] o_residue
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(EXP_BITS);

    t_state              r_state, n_state;
    logic [29:0]         r_acc, n_acc;
    logic [29:0]         r_base, n_base;
    logic [EXP_BITS-1:0] r_exp, n_exp;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [29:0]         r_residue, n_residue;

    logic        mm_start;
    logic [29:0] mm_b;
    logic        mm_done;
    logic [29:0] mm_product;
    logic [29:0] base_red;
    logic [63:0] exp_wide;
    logic        last_bit;
    logic        out_load;

    // shared modular multiplier, first operand is always the accumulator
    mexp_modmul u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mm_start),
        .i_a       (r_acc),
        .i_b       (mm_b),
        .o_done    (mm_done),
        .o_product (mm_product)
    );

    // input conditioning
    assign base_red = (i_base_value >= MOD) ? (i_base_value - MOD) : i_base_value;
    assign exp_wide = i_operation ? {34'd0, INV_EXP} : {32'd0, i_exponent};
    assign last_bit = (r_cnt == '0);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_residue   = r_residue;

    // sequencer: next state and datapath control
    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_base   = r_base;
        n_exp    = r_exp;
        n_cnt    = r_cnt;
        mm_start = 1'b0;
        mm_b     = r_acc;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_base = base_red;
                    n_exp  = exp_wide[EXP_BITS-1:0];
                    n_cnt  = CNT_W'(EXP_BITS - 1);
                    if (base_red == '0) begin
                        n_acc   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_acc   = 30'd1;
                        n_state = ST_SQ_GO;
                    end
                end
            end
            ST_SQ_GO: begin
                mm_start = 1'b1;
                mm_b     = r_acc;
                n_state  = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (mm_done) begin
                    n_acc = mm_product;
                    if (r_exp[EXP_BITS-1]) begin
                        n_state = ST_MUL_GO;
                    end else if (last_bit) begin
                        n_state = ST_DONE;
                    end else begin
                        n_cnt   = r_cnt - 1'b1;
                        n_exp   = r_exp << 1;
                        n_state = ST_SQ_GO;
                    end
                end
            end
            ST_MUL_GO: begin
                mm_start = 1'b1;
                mm_b     = r_base;
                n_state  = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mm_done) begin
                    n_acc = mm_product;
                    if (last_bit) begin
                        n_state = ST_DONE;
                    end else begin
                        n_cnt   = r_cnt - 1'b1;
                        n_exp   = r_exp << 1;
                        n_state = ST_SQ_GO;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_residue   = out_load ? r_acc : r_residue;
        n_out_valid = out_load | (r_out_valid & i_out_stall);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_base    <= n_base;
        r_exp     <= n_exp;
        r_cnt     <= n_cnt;
        r_residue <= n_residue;
    end

endmodule
